>>> rtl/sam_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stack allocator with marks.
// No dependencies; every other file imports this package.
package sam_pkg;

  // Parameter defaults
  localparam int unsigned PAGE_LOG2_DEF  = 12;
  localparam int unsigned ADDR_BITS_DEF  = 32;
  localparam int unsigned MARK_DEPTH_DEF = 16;

  // Field widths
  localparam int unsigned CMD_W          = 3;
  localparam int unsigned SIZE_W         = 32;
  localparam int unsigned ALIGN_W        = 4;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned COUNT_OUT_W    = 32;
  localparam int unsigned REGION_PAGES_W = 21;

  localparam logic [REGION_PAGES_W-1:0] REGION_PAGES_RST = 21'd256;

  // Mark slot: 8 bytes aligned to 8
  localparam logic [SIZE_W-1:0]  MARK_SLOT_BYTES      = 32'd8;
  localparam logic [ALIGN_W-1:0] MARK_SLOT_ALIGN_LOG2 = 4'd3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE_TO  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE_ALL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SAVE     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RESTORE  = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERRUN    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_BELOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MARKS_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_MARK    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE  = 3'd5;

  // Step strobes from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic align;
    logic sum;
    logic check;
    logic update;
  } dp_ctrl_t;

endpackage

>>> rtl/sam_in_if.sv
`timescale 1ns / 1ps
// Command channel: valid/ready handshake with the command payload.
// Depends on sam_pkg for the field widths.
interface sam_in_if import sam_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [SIZE_W-1:0]   size_bytes;
  logic [ALIGN_W-1:0]  align_log2;
  logic [ADDR_W-1:0]   address;

  modport source (output valid, command, size_bytes, align_log2, address, input ready);
  modport sink   (input valid, command, size_bytes, align_log2, address, output ready);
endinterface

>>> rtl/sam_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with the result payload.
// Depends on sam_pkg for the field widths.
interface sam_out_if import sam_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ADDR_W-1:0]      addr_out;
  logic [STATUS_W-1:0]    status;
  logic [COUNT_OUT_W-1:0] commit_change;
  logic [COUNT_OUT_W-1:0] committed_total;
  logic                   is_allocated;

  modport source (output valid, addr_out, status, commit_change, committed_total,
                  is_allocated, input ready);
  modport sink   (input valid, addr_out, status, commit_change, committed_total,
                  is_allocated, output ready);
endinterface

>>> rtl/sam_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences one command through the datapath steps and owns
// the handshake flags. Depends on sam_pkg for the step strobe struct.
module sam_ctrl import sam_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dp_ctrl_t dp_ctrl_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ALIGN  = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       slot_free;
  logic       commit_step;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  // the result register is free when empty or being drained this cycle
  assign slot_free   = !out_valid_q || out_ready_i;
  assign commit_step = (state_q == S_UPDATE) && slot_free;

  // Advance the step sequence; hold in update until the result slot frees
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_ALIGN;
      S_ALIGN:  state_d = S_SUM;
      S_SUM:    state_d = S_CHECK;
      S_CHECK:  state_d = S_UPDATE;
      S_UPDATE: if (slot_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Load the result flag on update, drop it once the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (commit_step) out_valid_d = 1'b1;
  end

  always_comb begin
    dp_ctrl_o.capture = accept;
    dp_ctrl_o.align   = (state_q == S_ALIGN);
    dp_ctrl_o.sum     = (state_q == S_SUM);
    dp_ctrl_o.check   = (state_q == S_CHECK);
    dp_ctrl_o.update  = commit_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/sam_dp.sv
`timescale 1ns / 1ps
// Datapath: top pointer, commit watermark, mark stack memory, region limit
// and the result registers. Depends on sam_pkg; driven by sam_ctrl strobes.
module sam_dp import sam_pkg::*; #(
  parameter int unsigned PAGE_LOG2  = PAGE_LOG2_DEF,
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF,
  parameter int unsigned MARK_DEPTH = MARK_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_ctrl_t                  dp_ctrl_i,
  input  logic                      cfg_we_i,
  input  logic [REGION_PAGES_W-1:0] cfg_wdata_i,
  input  logic [CMD_W-1:0]          command_i,
  input  logic [SIZE_W-1:0]         size_bytes_i,
  input  logic [ALIGN_W-1:0]        align_log2_i,
  input  logic [ADDR_W-1:0]         address_i,
  output logic [ADDR_W-1:0]         addr_out_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic [COUNT_OUT_W-1:0]    commit_change_o,
  output logic [COUNT_OUT_W-1:0]    committed_total_o,
  output logic                      is_allocated_o
);

  // Widths: top and watermark reach the region end itself
  localparam int unsigned AW    = (ADDR_BITS > PAGE_LOG2) ? ADDR_BITS : PAGE_LOG2;
  localparam int unsigned TW    = AW + 1;
  localparam int unsigned CW    = ((TW > SIZE_W) ? TW : SIZE_W) + 1;
  localparam int unsigned LIMW  = ADDR_BITS + 1;
  localparam int unsigned LW    = REGION_PAGES_W + PAGE_LOG2;
  localparam int unsigned CAPW  = (LW > LIMW) ? LW : LIMW;
  localparam int unsigned CNTW  = $clog2(MARK_DEPTH + 1);
  localparam int unsigned IW    = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(MARK_DEPTH);

  // Region size in bytes, capped at the address space
  function automatic logic [LIMW-1:0] pages_to_limit(input logic [REGION_PAGES_W-1:0] pages);
    logic [CAPW-1:0] bytes;
    logic [CAPW-1:0] cap;
    bytes = CAPW'(pages) << PAGE_LOG2;
    cap   = CAPW'(1) << ADDR_BITS;
    return (bytes > cap) ? cap[LIMW-1:0] : bytes[LIMW-1:0];
  endfunction

  // Architectural state
  logic [LIMW-1:0] limit_q;
  logic [TW-1:0]   top_q, top_d;
  logic [TW-1:0]   commit_q, commit_d;
  logic [CNTW-1:0] count_q, count_d;
  logic [TW-1:0]   mark_mem [MARK_DEPTH];
  logic [TW-1:0]   mark_rd_q;

  // Captured command
  logic [CMD_W-1:0]   cmd_q;
  logic [SIZE_W-1:0]  size_q;
  logic [ALIGN_W-1:0] align_q;
  logic [ADDR_W-1:0]  addr_q;

  // Step results
  logic [CW-1:0] aligned_q;
  logic [CW-1:0] new_top_q;
  logic [CW-1:0] page_up_q;
  logic          fits_q;
  logic          grow_q;

  logic               is_save;
  logic [SIZE_W-1:0]  eff_size;
  logic [ALIGN_W-1:0] eff_align;
  logic [CW-1:0]      align_mask;
  logic [CW-1:0]      page_mask;
  logic [CNTW-1:0]    count_dec;
  logic [IW-1:0]      rd_idx;
  logic [IW-1:0]      wr_idx;

  logic [CW-1:0]       addr_d;
  logic [STATUS_W-1:0] status_d;
  logic [CW-1:0]       change_d;
  logic                alloc_d;
  logic                push;
  logic [CW-1:0]       commit_wide;

  assign is_save    = (cmd_q == CMD_SAVE);
  assign eff_size   = is_save ? MARK_SLOT_BYTES : size_q;
  assign eff_align  = is_save ? MARK_SLOT_ALIGN_LOG2 : align_q;
  assign align_mask = ~({CW{1'b1}} << eff_align);
  assign page_mask  = ~({CW{1'b1}} << PAGE_LOG2);
  assign count_dec  = count_q - CNTW'(1);
  assign rd_idx     = count_dec[IW-1:0];
  assign wr_idx     = count_q[IW-1:0];

  // Capture the command on transfer
  always_ff @(posedge clk_i) begin
    if (dp_ctrl_i.capture) begin
      cmd_q   <= command_i;
      size_q  <= size_bytes_i;
      align_q <= align_log2_i;
      addr_q  <= address_i;
    end
  end

  // Align, add size, then range and commit checks, one step per cycle
  always_ff @(posedge clk_i) begin
    if (dp_ctrl_i.align) begin
      aligned_q <= (CW'(top_q) + align_mask) & ~align_mask;
    end
    if (dp_ctrl_i.sum) begin
      new_top_q <= aligned_q + CW'(eff_size);
    end
    if (dp_ctrl_i.check) begin
      fits_q    <= (new_top_q <= CW'(limit_q));
      grow_q    <= (new_top_q > CW'(commit_q));
      page_up_q <= (new_top_q + page_mask) & ~page_mask;
    end
  end

  // Mark stack memory: read the newest entry, push on a good save
  always_ff @(posedge clk_i) begin
    if (dp_ctrl_i.align) begin
      mark_rd_q <= mark_mem[rd_idx];
    end
    if (dp_ctrl_i.update && push) begin
      mark_mem[wr_idx] <= aligned_q[TW-1:0];
    end
  end

  // Decide the command's effect on state and its result
  always_comb begin
    top_d    = top_q;
    commit_d = commit_q;
    count_d  = count_q;
    push     = 1'b0;
    addr_d   = '0;
    status_d = ST_OK;
    change_d = '0;
    alloc_d  = 1'b0;
    unique case (cmd_q) inside
      CMD_ALLOC, CMD_SAVE: begin
        if (cmd_q == CMD_ALLOC && size_q == '0) begin
          status_d = ST_ZERO_SIZE;
        end else if (cmd_q == CMD_SAVE && count_q >= DEPTH_CNT) begin
          status_d = ST_MARKS_FULL;
        end else if (!fits_q) begin
          status_d = ST_OVERRUN;
        end else begin
          top_d  = new_top_q[TW-1:0];
          addr_d = aligned_q;
          if (grow_q) begin
            commit_d = page_up_q[TW-1:0];
            change_d = page_up_q - CW'(commit_q);
          end
          if (cmd_q == CMD_SAVE) begin
            push    = 1'b1;
            count_d = count_q + CNTW'(1);
          end
        end
      end
      CMD_FREE_TO: begin
        if (CW'(addr_q) < CW'(top_q)) begin
          top_d = TW'(addr_q);
        end else begin
          status_d = ST_NOT_BELOW;
        end
      end
      CMD_FREE_ALL: begin
        change_d = CW'(commit_q);
        top_d    = '0;
        commit_d = '0;
        count_d  = '0;
      end
      CMD_QUERY: begin
        alloc_d = (CW'(addr_q) < CW'(top_q));
      end
      CMD_RESTORE: begin
        if (count_q == '0) begin
          status_d = ST_NO_MARK;
        end else begin
          count_d = count_dec;
          top_d   = mark_rd_q;
          addr_d  = CW'(mark_rd_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign commit_wide = CW'(commit_d);

  // Control state: region limit, top, watermark, mark count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= pages_to_limit(REGION_PAGES_RST);
      top_q    <= '0;
      commit_q <= '0;
      count_q  <= '0;
    end else begin
      if (cfg_we_i) limit_q <= pages_to_limit(cfg_wdata_i);
      if (dp_ctrl_i.update) begin
        top_q    <= top_d;
        commit_q <= commit_d;
        count_q  <= count_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (dp_ctrl_i.update) begin
      addr_out_o        <= addr_d[ADDR_W-1:0];
      status_o          <= status_d;
      commit_change_o   <= change_d[COUNT_OUT_W-1:0];
      committed_total_o <= commit_wide[COUNT_OUT_W-1:0];
      is_allocated_o    <= alloc_d;
    end
  end

endmodule

>>> rtl/stack_allocator_with_marks.sv
`timescale 1ns / 1ps
// Stack bump allocator with save/restore marks over a paged region; offsets
// are relative to the region start. Each command passes through the
// transfer cycle, then four datapath steps (align the top, add the size,
// region and commit-watermark checks with page rounding, state update). The
// steps split the add/compare chain on the top pointer. The result sits in
// an output register, so the next command is taken while the previous result
// waits; its update step holds until that result has been transferred.
// Writing cfg_we_i/cfg_wdata_i sets the region size in pages (reset 256);
// write it only while no command is in flight.
module stack_allocator_with_marks import sam_pkg::*; #(
  parameter int unsigned PAGE_LOG2  = PAGE_LOG2_DEF,
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF,
  parameter int unsigned MARK_DEPTH = MARK_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  sam_in_if.sink                    in_ch,
  sam_out_if.source                 out_ch,
  input  logic                      cfg_we_i,
  input  logic [REGION_PAGES_W-1:0] cfg_wdata_i
);

  dp_ctrl_t dp_ctrl;

  // Sequence the steps and drive the handshakes
  sam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .dp_ctrl_o   (dp_ctrl)
  );

  // Hold allocator state and compute results
  sam_dp #(
    .PAGE_LOG2  (PAGE_LOG2),
    .ADDR_BITS  (ADDR_BITS),
    .MARK_DEPTH (MARK_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .dp_ctrl_i         (dp_ctrl),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .command_i         (in_ch.command),
    .size_bytes_i      (in_ch.size_bytes),
    .align_log2_i      (in_ch.align_log2),
    .address_i         (in_ch.address),
    .addr_out_o        (out_ch.addr_out),
    .status_o          (out_ch.status),
    .commit_change_o   (out_ch.commit_change),
    .committed_total_o (out_ch.committed_total),
    .is_allocated_o    (out_ch.is_allocated)
  );

endmodule

>>> sim/stack_allocator_with_marks_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stack_allocator_with_marks: directed and random command
// traffic with bursty input, a stalling result side and several region sizes.
// Depends on sam_pkg, sam_in_if, sam_out_if and the RTL top level.
module stack_allocator_with_marks_tb;
  import sam_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned SETTLE_GAP   = 8;    // margin after the last result transfer
  localparam int unsigned FINAL_WAIT   = 20;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned PAGE_BYTES   = 1 << PAGE_LOG2_DEF;

  // Command codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0]      addr;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] change;
    logic [COUNT_OUT_W-1:0] total;
    logic                   allocated;
  } alloc_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [REGION_PAGES_W-1:0] cfg_wdata_i;

  sam_in_if  in_ch ();
  sam_out_if out_ch ();

  stack_allocator_with_marks dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Mirror of the allocator state
  logic [63:0]               top_q;
  logic [63:0]               commit_q;
  logic [63:0]               mark_slots [MARK_DEPTH_DEF];
  int unsigned               mark_cnt;
  logic [REGION_PAGES_W-1:0] pages_q;

  alloc_result_t pending_results [$];
  int unsigned   mismatches;
  int unsigned   items_sent;
  int unsigned   burst_left;
  bit            gaps_on;
  bit            rx_hold;
  event          rx_hold_ev;

  // Region size in bytes, capped at the address space
  function automatic logic [63:0] region_limit();
    logic [63:0] bytes;
    bytes = 64'(pages_q) << PAGE_LOG2_DEF;
    if (bytes > (64'd1 << ADDR_BITS_DEF)) bytes = 64'd1 << ADDR_BITS_DEF;
    return bytes;
  endfunction

  // Bump the top; grow the commit watermark in whole pages
  function automatic logic [STATUS_W-1:0] bump_top(input logic [63:0] size,
                                                   input logic [ALIGN_W-1:0] align,
                                                   output logic [63:0] block,
                                                   output logic [63:0] grown);
    logic [63:0] mask;
    logic [63:0] aligned;
    logic [63:0] new_top;
    logic [63:0] page_mask;
    mask      = (64'd1 << align) - 64'd1;
    aligned   = (top_q + mask) & ~mask;
    new_top   = aligned + size;
    page_mask = 64'(PAGE_BYTES) - 64'd1;
    block     = '0;
    grown     = '0;
    if (new_top > region_limit()) return ST_OVERRUN;
    top_q = new_top;
    if (new_top > commit_q) begin
      grown    = (new_top - commit_q + page_mask) & ~page_mask;
      commit_q = commit_q + grown;
    end
    block = aligned;
    return ST_OK;
  endfunction

  // Advance the mirror by one command and return the result it should produce
  function automatic alloc_result_t step_allocator(input logic [CMD_W-1:0] cmd,
                                                   input logic [SIZE_W-1:0] size,
                                                   input logic [ALIGN_W-1:0] align,
                                                   input logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    logic [63:0]   block;
    logic [63:0]   change;
    r      = '0;
    block  = '0;
    change = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (size == '0) r.status = ST_ZERO_SIZE;
        else begin
          r.status = bump_top(64'(size), align, block, change);
          r.addr   = block[ADDR_W-1:0];
        end
      end
      CMD_FREE_TO: begin
        if (64'(addr) < top_q) top_q = 64'(addr);
        else r.status = ST_NOT_BELOW;
      end
      CMD_FREE_ALL: begin
        change   = commit_q;
        top_q    = '0;
        commit_q = '0;
        mark_cnt = 0;
      end
      CMD_QUERY: r.allocated = (64'(addr) < top_q);
      CMD_SAVE: begin
        if (mark_cnt >= MARK_DEPTH_DEF) r.status = ST_MARKS_FULL;
        else begin
          r.status = bump_top(64'(MARK_SLOT_BYTES), MARK_SLOT_ALIGN_LOG2, block, change);
          if (r.status == ST_OK) begin
            mark_slots[mark_cnt] = block;
            mark_cnt++;
            r.addr = block[ADDR_W-1:0];
          end
        end
      end
      CMD_RESTORE: begin
        if (mark_cnt == 0) r.status = ST_NO_MARK;
        else begin
          mark_cnt--;
          top_q  = mark_slots[mark_cnt];
          r.addr = top_q[ADDR_W-1:0];
        end
      end
      default: ;
    endcase
    r.change = change[COUNT_OUT_W-1:0];
    r.total  = commit_q[COUNT_OUT_W-1:0];
    return r;
  endfunction

  // Offer one command, wait for its transfer, record the expected result
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                          input logic [ALIGN_W-1:0] align, input logic [ADDR_W-1:0] addr);
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.size_bytes <= size;
    in_ch.align_log2 <= align;
    in_ch.address    <= addr;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    pending_results.push_back(step_allocator(cmd, size, align, addr));
    items_sent++;
    // End the burst with an idle gap
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left   = $urandom_range(1, 24);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(6, 20) : $urandom_range(1, 5))
          @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop valid and wait until the block has nothing in flight
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_GAP) @(posedge clk_i);
  endtask

  task automatic write_region(input logic [REGION_PAGES_W-1:0] pages);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pages;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pages_q      = pages;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r <= 2) return $urandom;
    if (r == 3) return 32'(region_limit() - top_q);
    if (r <= 12) return $urandom_range(1, 256);
    return $urandom_range(1, 16384);
  endfunction

  function automatic logic [ALIGN_W-1:0] pick_align();
    if ($urandom_range(0, 3) == 0) return ALIGN_W'($urandom_range(0, 15));
    return ALIGN_W'($urandom_range(0, 6));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return 32'(top_q);
      2:       return 32'(top_q - 64'd1);
      default: return (top_q == 0) ? 32'd0 : $urandom_range(0, 32'(top_q - 64'd1));
    endcase
  endfunction

  // Save, a few allocations and probes, maybe a partial free, then restore
  task automatic send_frame();
    int unsigned n;
    send_cmd(CMD_SAVE, $urandom, ALIGN_W'($urandom), $urandom);
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(0, 2) != 0) send_cmd(CMD_ALLOC, pick_size(), pick_align(), $urandom);
      else send_cmd(CMD_QUERY, $urandom, ALIGN_W'($urandom), pick_address());
    end
    if ($urandom_range(0, 2) == 0 && top_q != 0)
      send_cmd(CMD_FREE_TO, $urandom, ALIGN_W'($urandom),
               $urandom_range(0, 32'(top_q - 64'd1)));
    send_cmd(CMD_RESTORE, $urandom, ALIGN_W'($urandom), $urandom);
  endtask

  // Reset, then push marks up to and possibly past the stack depth and unwind
  task automatic send_mark_storm();
    int unsigned n;
    send_cmd(CMD_FREE_ALL, $urandom, ALIGN_W'($urandom), $urandom);
    n = $urandom_range(12, 18);
    repeat (n) begin
      send_cmd(CMD_SAVE, $urandom, ALIGN_W'($urandom), $urandom);
      if ($urandom_range(0, 1) == 0)
        send_cmd(CMD_ALLOC, $urandom_range(1, 64), ALIGN_W'($urandom_range(0, 4)), $urandom);
    end
    n = $urandom_range(0, 18);
    repeat (n) send_cmd(CMD_RESTORE, $urandom, ALIGN_W'($urandom), $urandom);
  endtask

  // Allocate large blocks, up to a quarter of the region each, which may overrun it
  task automatic send_fill();
    logic [63:0] quarter;
    quarter = region_limit() >> 2;
    repeat ($urandom_range(2, 8)) begin
      if (quarter == 0) send_cmd(CMD_ALLOC, $urandom_range(1, 8), pick_align(), $urandom);
      else send_cmd(CMD_ALLOC, $urandom_range(1, 32'(quarter)), pick_align(), $urandom);
    end
    if ($urandom_range(0, 1) == 0)
      send_cmd(CMD_FREE_ALL, $urandom, ALIGN_W'($urandom), $urandom);
  endtask

  task automatic test_alloc_basics();
    send_cmd(CMD_ALLOC, 32'd0, 4'd0, 32'd0);
    send_cmd(CMD_ALLOC, 32'd1, 4'd0, 32'd0);
    send_cmd(CMD_ALLOC, 32'd100, 4'd12, 32'd0);
    send_cmd(CMD_ALLOC, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF);
    send_cmd(CMD_QUERY, 32'd0, 4'd0, 32'(top_q - 64'd1));
    send_cmd(CMD_QUERY, 32'hFFFF_FFFF, 4'hF, 32'(top_q));
    send_cmd(CMD_FREE_TO, 32'd0, 4'd0, 32'(top_q));
    send_cmd(CMD_FREE_TO, 32'd0, 4'd0, 32'd1);
    // Fill exactly to the region end, then one byte more
    send_cmd(CMD_ALLOC, 32'(region_limit() - top_q), 4'd0, 32'd0);
    send_cmd(CMD_ALLOC, 32'd1, 4'd0, 32'd0);
    send_cmd(CMD_FREE_ALL, 32'd0, 4'd0, 32'd0);
    send_cmd(CMD_UNUSED_LO, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
    send_cmd(CMD_UNUSED_HI, 32'd5, 4'd3, 32'd7);
  endtask

  task automatic test_mark_nesting();
    send_cmd(CMD_RESTORE, 32'd0, 4'd0, 32'd0);
    send_cmd(CMD_SAVE, 32'd0, 4'd0, 32'd0);
    send_cmd(CMD_ALLOC, 32'd20, 4'd4, 32'd0);
    send_cmd(CMD_SAVE, 32'd0, 4'd0, 32'd0);
    // Free below the newer mark; restoring it must raise the top again
    send_cmd(CMD_FREE_TO, 32'd0, 4'd0, 32'd4);
    send_cmd(CMD_RESTORE, 32'd0, 4'd0, 32'd0);
    send_cmd(CMD_RESTORE, 32'd0, 4'd0, 32'd0);
    send_cmd(CMD_QUERY, 32'd0, 4'd0, 32'd0);
  endtask

  task automatic test_region_extremes();
    write_region('0);
    send_cmd(CMD_ALLOC, 32'd1, 4'd0, 32'd0);
    send_cmd(CMD_SAVE, 32'd0, 4'd0, 32'd0);
    write_region(21'd1048576);
    send_cmd(CMD_FREE_ALL, 32'd0, 4'd0, 32'd0);
    send_cmd(CMD_ALLOC, 32'hFFFF_FFFF, 4'd0, 32'd0);
    send_cmd(CMD_ALLOC, 32'd1, 4'd0, 32'd0);
    send_cmd(CMD_SAVE, 32'd0, 4'd0, 32'd0);
    send_cmd(CMD_FREE_ALL, 32'd0, 4'd0, 32'd0);
    write_region('1);
    send_cmd(CMD_ALLOC, 32'hFFFF_FFFF, 4'd15, 32'd0);
    send_cmd(CMD_QUERY, 32'd0, 4'd0, 32'hFFFF_FFFE);
    send_cmd(CMD_FREE_ALL, 32'd0, 4'd0, 32'd0);
    write_region(21'd1);
    send_cmd(CMD_ALLOC, 32'(PAGE_BYTES), 4'd0, 32'd0);
    send_cmd(CMD_FREE_ALL, 32'd0, 4'd0, 32'd0);
  endtask

  // Hold the result side off while commands keep coming
  task automatic test_output_stall();
    write_region(21'd256);
    gaps_on = 1'b0;
    -> rx_hold_ev;
    repeat (10) send_frame();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [REGION_PAGES_W-1:0] plan [8];
    int unsigned               phase_end;
    int unsigned               r;
    plan = '{21'd256, 21'd1, 21'd16, 21'd0, 21'd1048576, '1,
             21'($urandom_range(2, 1048575)), 21'($urandom_range(2, 4096))};
    foreach (plan[p]) begin
      write_region(plan[p]);
      gaps_on   = ($urandom_range(0, 3) != 0);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 35) send_cmd(CMD_W'($urandom), pick_size(), pick_align(), pick_address());
        else if (r < 75) send_frame();
        else if (r < 85) send_mark_storm();
        else send_fill();
      end
    end
    gaps_on = 1'b1;
  endtask

  // Compare one field and log a mismatch
  function automatic void check_field(input string label, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  // Check every transferred result against the oldest expectation
  always @(posedge clk_i) begin : result_check
    alloc_result_t want;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual addr %h status %0d",
                 $time, out_ch.addr_out, out_ch.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("addr_out", want.addr, out_ch.addr_out);
        check_field("status", 32'(want.status), 32'(out_ch.status));
        check_field("commit_change", want.change, out_ch.commit_change);
        check_field("committed_total", want.total, out_ch.committed_total);
        check_field("is_allocated", 32'(want.allocated), 32'(out_ch.is_allocated));
      end
    end
  end

  // Result-side pacing: a new stall mode every window, gated by the long hold
  always @(posedge clk_i) begin : rx_pace
    int unsigned mode;
    int unsigned window;
    bit          take;
    if (window == 0) begin
      mode   = $urandom_range(0, 3);
      window = $urandom_range(16, 96);
    end else begin
      window--;
    end
    case (mode)
      0:       take = 1'b1;
      1:       take = ($urandom_range(0, 1) == 1);
      2:       take = ($urandom_range(0, 3) == 0);
      default: take = (window[2:0] != 3'd0);
    endcase
    out_ch.ready <= take && !rx_hold;
  end

  // Long receiver hold-off, counted here
  initial begin
    forever begin
      @(rx_hold_ev);
      rx_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL stack_allocator_with_marks");
    $finish;
  end

  initial begin
    top_q      = '0;
    commit_q   = '0;
    mark_cnt   = 0;
    pages_q    = REGION_PAGES_RST;
    mismatches = 0;
    items_sent = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= '0;
    in_ch.size_bytes <= '0;
    in_ch.align_log2 <= '0;
    in_ch.address    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_alloc_basics();
    test_mark_nesting();
    test_region_extremes();
    test_output_stall();
    test_random_traffic();

    settle_idle();
    repeat (FINAL_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS stack_allocator_with_marks");
    end else begin
      $display("FAIL stack_allocator_with_marks");
    end
    $finish;
  end

endmodule
